// ===== src/positional_list_insert_delete_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the positional list sequencer, pli_seq
// Each macro expands to one labeled concurrent assertion on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_TOP_DEFINES_SVH

// Same-cycle implication
`define PLI_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define PLI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and codes for the positional list.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int OP_W   = 2;
	localparam int POS_W  = 6;
	localparam int DATA_W = 32;
	localparam int CNT_W  = 6;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic                     status;
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]         count;
	} res_t;

endpackage

// ===== src/pli_ram.sv =====
// ----------------------------------------------------------------------------
// pli_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/pli_seq.sv =====
// ----------------------------------------------------------------------------
// pli_seq
// Operation sequencer: checks a command, walks the entries that must move
// through the RAM one per cycle, then commits the count and the result.
// ----------------------------------------------------------------------------
module pli_seq import pli_pkg::*; #(
	parameter int CAPACITY = 32,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cmd_t              cmd,
	output logic              idle,
	input  logic              slot_free,
	output logic              done,
	output res_t              res,
	output logic              re,
	output logic [AW-1:0]     raddr,
	input  logic [DATA_W-1:0] rdata,
	output logic              we,
	output logic [AW-1:0]     waddr,
	output logic [DATA_W-1:0] wdata
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_MOVE  = 2'd1;
	localparam logic [1:0] S_FINAL = 2'd2;

	logic [1:0]        state_q;
	logic [CW-1:0]     cnt_q;
	logic [OP_W-1:0]   op_q;
	logic              ok_q;
	logic [AW-1:0]     pos_addr_q;
	logic [DATA_W-1:0] val_q;
	logic [AW-1:0]     rd_addr_q;
	logic [CW-1:0]     left_q;
	logic [DATA_W-1:0] rv_q;
	logic              pend_s1;
	logic [AW-1:0]     dest_s1;

	logic [7:0]    pos_w;
	logic [7:0]    cnt_w;
	logic [7:0]    cap_w;
	logic          ins_ok;
	logic          del_ok;
	logic          rd_ok;
	logic [CW-1:0] cnt_next;
	logic [7:0]    cnt_next_w;
	logic [AW-1:0] first_raddr;
	logic [CW-1:0] first_left;
	logic          ins_done;

	assign pos_w = {2'b00, cmd.position};
	assign cnt_w = 8'(cnt_q);
	assign cap_w = 8'(CAPACITY);

	assign ins_ok = (cmd.operation == OP_INSERT) && (cnt_w < cap_w) && (pos_w != 8'd0) &&
		(pos_w <= cnt_w + 8'd1);
	assign del_ok = (cmd.operation == OP_DELETE) && (pos_w != 8'd0) && (pos_w <= cnt_w);
	assign rd_ok  = (cmd.operation == OP_READ) && (pos_w != 8'd0) && (pos_w <= cnt_w);

	// Start address and number of moves for the incoming command
	always_comb begin
		first_raddr = AW'(pos_w - 8'd1);
		first_left  = '0;
		case (cmd.operation)
			OP_INSERT: begin
				// Walk down from the last entry to the target
				first_raddr = AW'(cnt_w - 8'd1);
				if (ins_ok) begin
					first_left = CW'(cnt_w - pos_w + 8'd1);
				end
			end
			OP_DELETE: begin
				// Walk up from the entry after the target
				first_raddr = AW'(pos_w);
				if (del_ok) begin
					first_left = CW'(cnt_w - pos_w);
				end
			end
			OP_READ: begin
				if (rd_ok) begin
					first_left = CW'(1);
				end
			end
			default: begin
				first_left = '0;
			end
		endcase
	end

	// One read per cycle while moves remain; each write lands in the cycle after its read
	assign re    = (state_q == S_MOVE) && (left_q != '0);
	assign raddr = rd_addr_q;

	always_comb begin
		we    = 1'b0;
		waddr = dest_s1;
		wdata = rdata;
		if (state_q == S_MOVE) begin
			we = pend_s1 && (op_q != OP_READ);
		end else if (state_q == S_FINAL) begin
			we    = slot_free && ok_q && (op_q == OP_INSERT);
			waddr = pos_addr_q;
			wdata = val_q;
		end
	end

	always_comb begin
		cnt_next = cnt_q;
		if (ok_q && (op_q == OP_INSERT)) begin
			cnt_next = cnt_q + CW'(1);
		end else if (ok_q && (op_q == OP_DELETE)) begin
			cnt_next = cnt_q - CW'(1);
		end
	end

	assign cnt_next_w     = 8'(cnt_next);
	assign res.status     = !ok_q;
	assign res.read_value = (ok_q && (op_q == OP_READ)) ? rv_q : '0;
	assign res.count      = cnt_next_w[CNT_W-1:0];

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_FINAL) && slot_free;

	assign ins_done = done && ok_q && (op_q == OP_INSERT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (start) begin
						state_q <= S_MOVE;
					end
				end
				S_MOVE: begin
					pend_s1 <= re;
					if ((left_q == '0) && !pend_s1) begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					if (slot_free) begin
						cnt_q   <= cnt_next;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			if (start) begin
				op_q       <= cmd.operation;
				val_q      <= cmd.value;
				pos_addr_q <= AW'(pos_w - 8'd1);
				rv_q       <= '0;
				ok_q       <= ins_ok || del_ok || rd_ok;
				rd_addr_q  <= first_raddr;
				left_q     <= first_left;
			end
		end else if (state_q == S_MOVE) begin
			if (re) begin
				left_q <= left_q - CW'(1);
				if (op_q == OP_INSERT) begin
					rd_addr_q <= rd_addr_q - AW'(1);
					dest_s1   <= rd_addr_q + AW'(1);
				end else begin
					rd_addr_q <= rd_addr_q + AW'(1);
					dest_s1   <= rd_addr_q - AW'(1);
				end
			end
			if (pend_s1 && (op_q == OP_READ)) begin
				rv_q <= rdata;
			end
		end
	end

	`include "positional_list_insert_delete_top_defines.svh"

	`PLI_ASSERT_IMPL(a_cnt_cap, 1'b1, cnt_q <= CW'(CAPACITY), "entry count above capacity")
	`PLI_ASSERT_IMPL(a_no_wr_idle, state_q == S_IDLE, !we, "RAM write while idle")
	`PLI_ASSERT_IMPL(a_rw_apart, re && we, raddr != waddr, "read and write hit one entry")
	`PLI_ASSERT_NEXT(a_ins_cnt, ins_done, cnt_q == $past(cnt_q) + CW'(1), "insert missed count")
	`PLI_ASSERT_IMPL(a_start_idle, start, state_q == S_IDLE, "command started while busy")

endmodule

// ===== src/positional_list_insert_delete_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top
// Ordered list of signed 32-bit words with insert, delete and read by
// one-based position; one result word per command word.
// ----------------------------------------------------------------------------
// The list lives in a single simple dual-port RAM of CAPACITY words, and every
// entry that an insert or delete must shift goes through that RAM's one read
// and one write port, one entry per cycle. A command word is taken only while
// the block is idle; it then holds off until that command has finished. A new
// command word is taken while the previous result waits in the output
// register; a finished result that finds that register still full holds the
// block until the register is taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_top import pli_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  logic [OP_W-1:0]          operation,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic                     status,
	output logic signed [DATA_W-1:0] read_value,
	output logic [CNT_W-1:0]         count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	cmd_t              cmd;
	res_t              res;
	logic              start;
	logic              idle;
	logic              slot_free;
	logic              done;
	logic              re;
	logic              we;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] rdata;
	logic [DATA_W-1:0] wdata;

	logic              res_valid_q;
	res_t              res_q;

	assign cmd.operation = operation;
	assign cmd.position  = position;
	assign cmd.value     = value;

	assign cmd_ready = idle;
	assign start     = cmd_valid && cmd_ready;
	assign slot_free = !res_valid_q || res_ready;

	pli_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.idle     (idle),
		.slot_free(slot_free),
		.done     (done),
		.res      (res),
		.re       (re),
		.raddr    (raddr),
		.rdata    (rdata),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata)
	);

	pli_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	assign res_valid  = res_valid_q;
	assign status     = res_q.status;
	assign read_value = res_q.read_value;
	assign count      = res_q.count;

endmodule
